### sv/scvb_pkg.sv
// ----------------------------------------------------------------------------
// scvb_pkg: shared types and constants for the stereo cost volume builder
// Sizes of the disparity range and channel count, the sequencer state type
// and the requantize function used on both feature paths.
// ----------------------------------------------------------------------------
`default_nettype none

package scvb_pkg;

	// geometry
	localparam int DISP     = 48;
	localparam int CHANNELS = 32;

	// derived widths
	localparam int SLOT_W = $clog2(DISP);             // ring slot, also disparity index
	localparam int COL_W  = $clog2(DISP + 1);         // column count, saturates at DISP
	localparam int CHAN_W = $clog2(CHANNELS);
	localparam int ADDR_W = $clog2(DISP * CHANNELS);
	localparam int DEPTH  = DISP * CHANNELS;

	// fixed field widths
	localparam int FEAT_W  = 8;
	localparam int SHIFT_W = 4;
	localparam int DISPO_W = 6;
	localparam int CHANO_W = 5;

	typedef logic signed [FEAT_W-1:0]  feat_t;
	typedef logic signed [SHIFT_W-1:0] shift_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} scvb_state_t;

	// Requantize one element. Positive shift: arithmetic right shift rounding
	// half up. Negative shift: left shift wrapping in 8 bits (minus eight
	// clears every bit). Zero: copy.
	function automatic feat_t requant(input feat_t x, input shift_t s);
		logic [SHIFT_W-1:0] k;
		feat_t              a;
		feat_t              b;
		feat_t              r;
		k = 4'(-s);
		a = x >>> s[2:0];
		b = x >>> (s[2:0] - 3'd1);
		if (s > 0) begin
			r = a + feat_t'({7'd0, b[0]});
		end else if (s < 0) begin
			r = x << k;
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/scvb_feat_if.sv
// ----------------------------------------------------------------------------
// scvb_feat_if: input feature channel
// One item is one channel element of one pixel: left and right values and
// the row-start mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface scvb_feat_if;
	logic                     valid;
	logic                     ready;
	logic signed [7:0]        left_value;
	logic signed [7:0]        right_value;
	logic                     new_row;

	modport source (output valid, output left_value, output right_value, output new_row,
		input ready);
	modport sink (input valid, input left_value, input right_value, input new_row,
		output ready);
endinterface

`default_nettype wire

### sv/scvb_cost_if.sv
// ----------------------------------------------------------------------------
// scvb_cost_if: output cost volume channel
// One item is one left/right pair for one disparity of one element.
// ----------------------------------------------------------------------------
`default_nettype none

interface scvb_cost_if;
	logic                     valid;
	logic                     ready;
	logic signed [7:0]        left_out;
	logic signed [7:0]        right_out;
	logic [5:0]               disparity;
	logic [4:0]               chan_index;
	logic                     last;

	modport source (output valid, output left_out, output right_out, output disparity,
		output chan_index, output last, input ready);
	modport sink (input valid, input left_out, input right_out, input disparity,
		input chan_index, input last, output ready);
endinterface

`default_nettype wire

### sv/scvb_cfg_if.sv
// ----------------------------------------------------------------------------
// scvb_cfg_if: configuration write channel
// Carries the requantize shift register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface scvb_cfg_if;
	logic                     valid;
	logic                     ready;
	logic signed [3:0]        act_shift;

	modport source (output valid, output act_shift, input ready);
	modport sink (input valid, input act_shift, output ready);
endinterface

`default_nettype wire

### sv/scvb_ram.sv
// ----------------------------------------------------------------------------
// scvb_ram: simple dual-port synchronous RAM
// One write port, one read port with a registered read that holds its data
// while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module scvb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### sv/stereo_cost_volume_builder_core.sv
// ----------------------------------------------------------------------------
// stereo_cost_volume_builder_core: concatenation cost volume builder
// Pairs each left feature element with the right elements of the last
// DISP pixels of the row, one result per disparity.
// ----------------------------------------------------------------------------
// Each accepted element writes its right value into a ring memory of
// DISP x CHANNELS bytes and then produces DISP results, disparity 0 first,
// at one result per clock unless the output stalls, from a single memory
// read port. An element is first accepted and written, then one read is
// issued per disparity; the next element is accepted as soon as the last
// read of the current one has issued, while its final results still drain
// through the read and output registers. Results for disparities beyond
// the pixel's column carry zero on both values. The act_shift register may
// only be written while the block is idle; it is applied to the left value
// on accept, to the right value at the output. The ring memory needs no clearing.
`default_nettype none

module stereo_cost_volume_builder_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	scvb_cfg_if.sink   cfg,
	scvb_feat_if.sink  feat,
	scvb_cost_if.source cost
);

	import scvb_pkg::*;

	// configuration
	shift_t              act_shift_q;

	// row position state
	logic [SLOT_W-1:0]   ring_q;
	logic [COL_W-1:0]    col_q;
	logic [CHAN_W-1:0]   chan_q;

	// current element under sequencing
	scvb_state_t         state_q;
	scvb_state_t         state_d;
	logic [SLOT_W-1:0]   m_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COL_W-1:0]    item_col_q;
	logic [CHAN_W-1:0]   item_chan_q;
	feat_t               left_rq_q;

	// read stage
	logic                valid_s1;
	logic [SLOT_W-1:0]   m_s1;
	logic                pad_s1;
	logic [CHAN_W-1:0]   chan_s1;
	feat_t               left_s1;

	// output register
	logic                out_valid_q;
	feat_t               left_out_q;
	feat_t               right_out_q;
	logic [DISPO_W-1:0]  disp_out_q;
	logic [CHANO_W-1:0]  chan_out_q;
	logic                last_out_q;

	// control
	logic                accept;
	logic                issue;
	logic                out_free;
	logic                adv_s1;
	logic                in_ready;
	logic                pad_now;
	logic [CHAN_W-1:0]   chan_eff;
	logic [COL_W-1:0]    col_eff;
	logic [ADDR_W-1:0]   waddr;
	logic [ADDR_W-1:0]   raddr;
	logic [FEAT_W-1:0]   rdata;

	// configuration port: always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_shift_q <= '0;
		end else if (cfg.valid) begin
			act_shift_q <= cfg.act_shift;
		end
	end

	// handshake and stage movement
	assign out_free = !out_valid_q || cost.ready;
	assign adv_s1   = valid_s1 && out_free;
	assign accept   = feat.valid && in_ready;
	assign feat.ready = in_ready;

	// sequencer: next state, ready and read issue
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (feat.valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = !valid_s1 || out_free;
				if (issue && (m_q == SLOT_W'(DISP - 1))) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// row mark restarts column and channel before the element is handled
	assign chan_eff = feat.new_row ? '0 : chan_q;
	assign col_eff  = feat.new_row ? '0 : col_q;

	// row position update at each accepted element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
			col_q  <= '0;
			chan_q <= '0;
		end else if (accept) begin
			if (chan_eff == CHAN_W'(CHANNELS - 1)) begin
				chan_q <= '0;
				ring_q <= (ring_q == SLOT_W'(DISP - 1)) ? '0 : ring_q + 1'b1;
				col_q  <= (col_eff < COL_W'(DISP)) ? col_eff + 1'b1 : col_eff;
			end else begin
				chan_q <= chan_eff + 1'b1;
				col_q  <= col_eff;
			end
		end
	end

	// per-element context and disparity walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= '0;
		end else if (accept) begin
			m_q <= '0;
		end else if (issue) begin
			m_q <= m_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q      <= ring_q;
			item_col_q  <= col_eff;
			item_chan_q <= chan_eff;
			left_rq_q   <= requant(feat.left_value, act_shift_q);
		end else if (issue) begin
			slot_q <= (slot_q == '0) ? SLOT_W'(DISP - 1) : slot_q - 1'b1;
		end
	end

	// ring memory: write on accept, read one slot per disparity
	assign waddr = ADDR_W'(ADDR_W'(ring_q) * ADDR_W'(CHANNELS) + ADDR_W'(chan_eff));
	assign raddr = ADDR_W'(ADDR_W'(slot_q) * ADDR_W'(CHANNELS) + ADDR_W'(item_chan_q));

	scvb_ram #(
		.WIDTH (FEAT_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (waddr),
		.wdata (feat.right_value),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	// padding: column less than disparity
	assign pad_now = item_col_q < COL_W'(m_q);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			m_s1    <= m_q;
			pad_s1  <= pad_now;
			chan_s1 <= item_chan_q;
			left_s1 <= pad_now ? '0 : left_rq_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (cost.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			left_out_q  <= left_s1;
			right_out_q <= pad_s1 ? '0 : requant(feat_t'(rdata), act_shift_q);
			disp_out_q  <= DISPO_W'(m_s1);
			chan_out_q  <= CHANO_W'(chan_s1);
			last_out_q  <= (m_s1 == SLOT_W'(DISP - 1));
		end
	end

	assign cost.valid      = out_valid_q;
	assign cost.left_out   = left_out_q;
	assign cost.right_out  = right_out_q;
	assign cost.disparity  = disp_out_q;
	assign cost.chan_index = chan_out_q;
	assign cost.last       = last_out_q;

endmodule

`default_nettype wire

### test/stereo_cost_volume_builder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_cost_volume_builder_core_tb: self-checking bench for the cost volume
// Feeds rows of feature elements under a range of requantize shifts. Every
// accepted item is run through a local model of the ring memory and the
// requantizer, and each result is matched in order against its forecast.
// ----------------------------------------------------------------------------

module stereo_cost_volume_builder_core_tb;

	import scvb_pkg::*;

	// one expected or observed cost volume result
	typedef struct packed {
		feat_t      left_out;
		feat_t      right_out;
		logic [5:0] disparity;
		logic [4:0] chan_index;
		logic       last;
	} cost_t;

	// worst case: every result held by the longest stall, with sender gaps on top
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int          RAND_ITEMS  = 200;
	localparam int          LONG_PIXELS = 5;

	// ------------------------------------------------------------------------
	// Cost scoreboard: forecasts DISP results per element, checks them in order
	// ------------------------------------------------------------------------
	class cost_volume_checker;
		cost_t       expected_costs[$];
		int          col_cnt;
		int          ring_ptr;
		int          chan_cnt;
		int          shift;
		feat_t       right_hist [DEPTH];
		int unsigned n_checked;
		int unsigned n_errors;

		function new();
			col_cnt   = 0;
			ring_ptr  = 0;
			chan_cnt  = 0;
			shift     = 0;
			n_checked = 0;
			n_errors  = 0;
		endfunction

		function void set_shift(int s);
			shift = s;
		endfunction

		function int pending();
			return expected_costs.size();
		endfunction

		// rounding right shift, wrapping left shift, or copy
		function feat_t requantize(feat_t x);
			int xi;
			int hi;
			int lo;
			xi = x;
			if (shift > 0) begin
				hi = xi >>> shift;
				lo = xi >>> (shift - 1);
				return feat_t'(hi + (lo & 1));
			end
			if (shift < 0) begin
				return feat_t'(xi << (-shift));
			end
			return x;
		endfunction

		task report(string msg);
			n_errors++;
			if (n_errors <= 30) begin
				$display("ERROR: %s", msg);
			end
		endtask

		// an item was accepted: store its right value and forecast the results
		function void note_element(feat_t l, feat_t r, logic nr);
			cost_t c;
			int    chan;
			int    slot;
			if (nr) begin
				col_cnt  = 0;
				chan_cnt = 0;
			end
			chan = chan_cnt;
			right_hist[ring_ptr * CHANNELS + chan] = r;
			for (int m = 0; m < DISP; m++) begin
				c.disparity  = 6'(m);
				c.chan_index = 5'(chan);
				c.last       = (m == DISP - 1);
				if (col_cnt < m) begin
					c.left_out  = '0;
					c.right_out = '0;
				end else begin
					slot        = (ring_ptr + DISP - m) % DISP;
					c.left_out  = requantize(l);
					c.right_out = requantize(right_hist[slot * CHANNELS + chan]);
				end
				expected_costs.insert(expected_costs.size(), c);
			end
			// pixel boundary: wrap channel, advance ring, saturate column
			chan_cnt = chan + 1;
			if (chan_cnt >= CHANNELS) begin
				chan_cnt = 0;
				ring_ptr = (ring_ptr + 1) % DISP;
				if (col_cnt < DISP) begin
					col_cnt++;
				end
			end
		endfunction

		task check_cost(cost_t got);
			cost_t want;
			if (expected_costs.size() == 0) begin
				report($sformatf("result with nothing expected: d=%0d c=%0d l=%0d r=%0d",
					got.disparity, got.chan_index, got.left_out, got.right_out));
				return;
			end
			want = expected_costs.pop_front();
			n_checked++;
			if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
					got.disparity !== want.disparity || got.chan_index !== want.chan_index ||
					got.last !== want.last) begin
				report($sformatf({"result %0d: got l=%0d r=%0d d=%0d c=%0d last=%0b,",
					" want l=%0d r=%0d d=%0d c=%0d last=%0b"}, n_checked,
					got.left_out, got.right_out, got.disparity, got.chan_index, got.last,
					want.left_out, want.right_out, want.disparity, want.chan_index,
					want.last));
			end
		endtask

		task check_drained();
			if (expected_costs.size() != 0) begin
				report($sformatf("%0d results never arrived", expected_costs.size()));
			end
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	scvb_cfg_if  cfg_ch ();
	scvb_feat_if feat_ch ();
	scvb_cost_if cost_ch ();

	stereo_cost_volume_builder_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.feat   (feat_ch),
		.cost   (cost_ch)
	);

	always #5 clk = ~clk;

	cost_volume_checker sb;
	cost_t              seen_cost;
	int unsigned        n_cycles = 0;
	int unsigned        n_items = 0;
	int unsigned        n_shift_writes = 0;
	int                 burst_left = 0;
	bit                 steady = 1'b0;
	int unsigned        rx_left = 0;
	logic               rx_on = 1'b0;

	// directed items: extremes, alternating bit patterns, a mark inside a pixel
	feat_t dir_left  [10] = '{-128, 127, 0, -1, 1, 85, -86, 64, -65, -127};
	feat_t dir_right [10] = '{127, -128, 0, -1, 1, -86, 85, -64, 63, 126};
	bit    dir_mark  [10] = '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0};

	// ------------------------------------------------------------------------
	// Receiver: ready runs and stalls of random length, some long open runs
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_on = ~rx_on;
			if (rx_on) begin
				rx_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 30);
			end else begin
				rx_left = $urandom_range(1, 6);
			end
		end
		rx_left--;
		cost_ch.ready <= rx_on;
	end

	// results are sampled mid-cycle, ahead of the accepting edge
	always @(negedge clk) begin
		if (arst_n === 1'b1 && cost_ch.valid === 1'b1 && cost_ch.ready === 1'b1) begin
			seen_cost.left_out   = cost_ch.left_out;
			seen_cost.right_out  = cost_ch.right_out;
			seen_cost.disparity  = cost_ch.disparity;
			seen_cost.chan_index = cost_ch.chan_index;
			seen_cost.last       = cost_ch.last;
			sb.check_cost(seen_cost);
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("stereo_cost_volume_builder_core test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	function automatic feat_t rand_feat();
		case ($urandom_range(0, 11))
			0:       return feat_t'(8'h80);
			1:       return feat_t'(8'h7F);
			2:       return feat_t'(8'h00);
			3:       return feat_t'(8'hFF);
			default: return feat_t'($urandom_range(0, 255));
		endcase
	endfunction

	// one item, in bursts with random gaps unless the phase is steady
	task automatic send_item(input feat_t l, input feat_t r, input logic nr);
		int  gap;
		bit  taken;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				feat_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		feat_ch.valid       <= 1'b1;
		feat_ch.left_value  <= l;
		feat_ch.right_value <= r;
		feat_ch.new_row     <= nr;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = (feat_ch.ready === 1'b1);
			@(posedge clk);
		end
		sb.note_element(l, r, nr);
		n_items++;
	endtask

	task automatic send_row(input int pixels, input int tail, input bit mark);
		for (int k = 0; k < pixels * CHANNELS + tail; k++) begin
			send_item(rand_feat(), rand_feat(), mark && (k == 0));
		end
	endtask

	task automatic run_directed(input int n, input bit first_mark);
		for (int k = 0; k < n; k++) begin
			send_item(dir_left[k], dir_right[k], dir_mark[k] | (first_mark && k == 0));
		end
	endtask

	// shift write once the block has drained
	task automatic write_shift(input int s);
		bit taken;
		feat_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.act_shift <= 4'(s);
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = (cfg_ch.ready === 1'b1);
			@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		sb.set_shift(s);
		n_shift_writes++;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int shift_plan [6];
		int start;
		int row_no;
		int kind;
		shift_plan = '{-7, 1, -1, 4, 6, -3};
		sb = new();
		arst_n              = 1'b0;
		feat_ch.valid       = 1'b0;
		feat_ch.left_value  = '0;
		feat_ch.right_value = '0;
		feat_ch.new_row     = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.act_shift    = '0;
		cost_ch.ready       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: copy, strongest right shift, shift of minus eight
		write_shift(0);
		run_directed(10, 1'b0);
		write_shift(7);
		run_directed(7, 1'b1);
		write_shift(-8);
		run_directed(7, 1'b1);

		// one longer row: the column walks over several pixels back to back
		write_shift($urandom_range(0, 15) - 8);
		steady = 1'b1;
		send_row(LONG_PIXELS, 0, 1'b1);

		// random rows, mostly well formed, some broken or unmarked
		start  = n_items;
		row_no = 0;
		while (n_items - start < RAND_ITEMS) begin
			write_shift((row_no < 6) ? shift_plan[row_no] : $urandom_range(0, 15) - 8);
			steady = ($urandom_range(0, 3) == 0);
			kind   = $urandom_range(0, 9);
			if (kind < 7) begin
				send_row($urandom_range(1, 3), 0, 1'b1);
			end else if (kind == 7) begin
				send_row($urandom_range(0, 1), $urandom_range(1, CHANNELS - 1), 1'b1);
			end else if (kind == 8) begin
				send_row(1, 0, 1'b0);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_item(rand_feat(), rand_feat(), 1'($urandom_range(0, 1)));
				end
			end
			row_no++;
		end

		// drain, then allow for anything stray
		feat_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DISP + 8) @(posedge clk);
		sb.check_drained();

		$display("Covered %0d elements and %0d results over %0d shift writes,",
			n_items, sb.n_checked, n_shift_writes);
		$display("including a %0d-pixel row and %0d random rows; %0d mismatches.",
			LONG_PIXELS, row_no, sb.n_errors);
		if (sb.n_errors == 0) begin
			$display("stereo_cost_volume_builder_core test passed");
		end else begin
			$display("stereo_cost_volume_builder_core test failed");
		end
		$finish;
	end

endmodule
